[hdl/twc_pkg.sv]
package twc_pkg;

    // Fraction bits of the coefficient and fixed-point internals.
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_W         = 17;
    localparam int Q_FRAC         = 30;
    localparam int DIV_STEPS      = 30;
    localparam int HORNER_STEPS   = 6;
    localparam int RECIP_SHIFT    = 32;

    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [16:0] ALPHA_ONE   = 17'h1_0000;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [1:0] REG_TAPER_RATIO   = 2'd1;

    // Horner divisors, applied in this order.
    function automatic int horner_div(input int k);
        int d;
        begin
            d = 6;
            unique case (k)
                0: d = 156;
                1: d = 110;
                2: d = 72;
                3: d = 42;
                4: d = 20;
                default: d = 6;
            endcase
            return d;
        end
    endfunction

    // Control that travels alongside each word through the pipeline.
    typedef struct packed {
        logic valid;
        logic idx_valid;
        logic bypass;
    } twc_tag_t;

endpackage

[hdl/twc_div_cell.sv]
module twc_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  twc_pkg::twc_tag_t tag_in,
    input  logic [29:0]       rem_in,
    input  logic [29:0]       den_in,
    input  logic [29:0]       quo_in,
    output twc_pkg::twc_tag_t tag_out,
    output logic [29:0]       rem_out,
    output logic [29:0]       den_out,
    output logic [29:0]       quo_out
);
    import twc_pkg::*;

    // One restoring step: double the partial remainder and try the divisor.
    logic [30:0] shifted;
    logic        fits;
    logic [30:0] diff;

    twc_tag_t    tag_reg;
    logic [29:0] rem_reg;
    logic [29:0] den_reg;
    logic [29:0] quo_reg;

    assign shifted = {rem_in, 1'b0};
    assign fits    = shifted >= {1'b0, den_in};
    assign diff    = shifted - {1'b0, den_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= fits ? diff[29:0] : shifted[29:0];
            den_reg <= den_in;
            quo_reg <= {quo_in[28:0], fits};
        end
    end

    assign tag_out = tag_reg;
    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign quo_out = quo_reg;
endmodule

[hdl/twc_horner_cell.sv]
module twc_horner_cell #(
    parameter int DIVISOR = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  twc_pkg::twc_tag_t tag_in,
    input  logic [30:0]       theta_in,
    input  logic [31:0]       t2_in,
    input  logic [30:0]       b_in,
    output twc_pkg::twc_tag_t tag_out,
    output logic [30:0]       theta_out,
    output logic [31:0]       t2_out,
    output logic [30:0]       b_out
);
    import twc_pkg::*;

    localparam logic [39:0] RECIP = 40'((64'd1 << RECIP_SHIFT) / DIVISOR);
    localparam logic [7:0]  KDIV  = 8'(DIVISOR);

    // Three stages: product, reciprocal multiply, correction and subtract.
    twc_tag_t    tag_reg [3];
    logic [30:0] theta_reg [3];
    logic [31:0] t2_reg [3];

    logic [62:0] prod;
    logic [31:0] p1_reg;
    logic [71:0] pm_reg;
    logic [31:0] p2_reg;
    logic [31:0] q0;
    logic [31:0] rem;
    logic [31:0] q;
    logic [30:0] b_reg;
    logic [30:0] b_next;

    assign prod = 63'(t2_in) * 63'(b_in);
    assign q0   = 32'(pm_reg >> RECIP_SHIFT);
    assign rem  = p2_reg - 32'(q0 * 32'(KDIV));
    assign q    = q0 + ((rem >= 32'(KDIV)) ? 32'd1 : 32'd0);

    always_comb
    begin
        if (q >= 32'(Q30_ONE))
        begin
            b_next = '0;
        end
        else
        begin
            b_next = Q30_ONE - q[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
            tag_reg[1] <= '0;
            tag_reg[2] <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
            tag_reg[1] <= tag_reg[0];
            tag_reg[2] <= tag_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            theta_reg[0] <= theta_in;
            theta_reg[1] <= theta_reg[0];
            theta_reg[2] <= theta_reg[1];
            t2_reg[0]    <= t2_in;
            t2_reg[1]    <= t2_reg[0];
            t2_reg[2]    <= t2_reg[1];
            p1_reg       <= prod[61:30];
            pm_reg       <= 72'(p1_reg) * 72'(RECIP);
            p2_reg       <= p1_reg;
            b_reg        <= b_next;
        end
    end

    assign tag_out   = tag_reg[2];
    assign theta_out = theta_reg[2];
    assign t2_out    = t2_reg[2];
    assign b_out     = b_reg;
endmodule

[hdl/tukey_window_coefficient_unit.sv]
// Channel   Valid      Stall      Word
// input     in_valid   in_stall   sample_index
// output    out_valid  out_stall  coefficient, index_valid
// config    cfg_we     -          cfg_index, cfg_data
//
// One word is taken per clock while no output word is held by out_stall.
// The pipeline holds the thirty cells of the restoring divider, one
// quotient bit per cell, and the six three-stage Horner cells for the sine.
// Reset clears every valid flag and loads a length of 64 and a taper of one half.
// While the output word is held by out_stall the whole pipeline freezes, so
// in_stall follows out_valid and out_stall.
module tukey_window_coefficient_unit #(
    parameter int MAX_LENGTH = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] sample_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [16:0] coefficient,
    output logic        index_valid
);
    import twc_pkg::*;

    logic [12:0] window_length_reg;
    logic [16:0] taper_ratio_reg;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= 13'd64;
            taper_ratio_reg   <= 17'd32768;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_LENGTH: window_length_reg <= cfg_data[12:0];
                REG_TAPER_RATIO:   taper_ratio_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // The whole pipeline advances unless a finished word is being held.
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // Front stage: clamp, mirror the index and form the divisor alpha*(L-1).
    logic [12:0] len_c;
    logic [16:0] a_c;
    logic        iv;
    logic [12:0] last_l;
    logic [12:0] mirror;
    logic [11:0] m;
    logic [29:0] den;
    logic        bypass;

    always_comb
    begin
        if (32'(window_length_reg) > 32'(MAX_LENGTH))
        begin
            len_c = 13'(MAX_LENGTH);
        end
        else
        begin
            len_c = window_length_reg;
        end
        a_c    = (taper_ratio_reg > ALPHA_ONE) ? ALPHA_ONE : taper_ratio_reg;
        iv     = {1'b0, sample_index} < len_c;
        last_l = len_c - 13'd1;
        mirror = last_l - {1'b0, sample_index};
        m      = ({1'b0, sample_index} < mirror) ? sample_index : mirror[11:0];
        den    = 30'(a_c) * 30'(last_l);
        bypass = !iv || (a_c == '0) || ({1'b0, m, 17'd0} >= den);
    end

    twc_tag_t    div_tag [DIV_STEPS+1];
    logic [29:0] div_rem [DIV_STEPS+1];
    logic [29:0] div_den [DIV_STEPS+1];
    logic [29:0] div_quo [DIV_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_tag[0] <= '0;
        end
        else if (adv)
        begin
            div_tag[0] <= '{valid: in_valid, idx_valid: iv, bypass: bypass};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_rem[0] <= {1'b0, m, 17'd0};
            div_den[0] <= den;
            div_quo[0] <= '0;
        end
    end

    // Divider chain: x = (m << 47) / (alpha*(L-1)), one quotient bit per cell.
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        twc_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .tag_in  (div_tag[i]),
            .rem_in  (div_rem[i]),
            .den_in  (div_den[i]),
            .quo_in  (div_quo[i]),
            .tag_out (div_tag[i+1]),
            .rem_out (div_rem[i+1]),
            .den_out (div_den[i+1]),
            .quo_out (div_quo[i+1])
        );
    end

    // Angle theta = x*pi/2 and its square.
    twc_tag_t    th_tag_reg;
    logic [30:0] theta_reg;
    twc_tag_t    sq_tag_reg;
    logic [30:0] sq_theta_reg;
    logic [31:0] t2_reg;
    logic [60:0] theta_prod;
    logic [61:0] t2_prod;

    assign theta_prod = 61'(div_quo[DIV_STEPS]) * 61'(HALF_PI_Q30);
    assign t2_prod    = 62'(theta_reg) * 62'(theta_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            th_tag_reg <= '0;
            sq_tag_reg <= '0;
        end
        else if (adv)
        begin
            th_tag_reg <= div_tag[DIV_STEPS];
            sq_tag_reg <= th_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            theta_reg    <= theta_prod[60:30];
            sq_theta_reg <= theta_reg;
            t2_reg       <= t2_prod[61:30];
        end
    end

    // Horner chain for the sine series.
    twc_tag_t    h_tag [HORNER_STEPS+1];
    logic [30:0] h_theta [HORNER_STEPS+1];
    logic [31:0] h_t2 [HORNER_STEPS+1];
    logic [30:0] h_b [HORNER_STEPS+1];

    assign h_tag[0]   = sq_tag_reg;
    assign h_theta[0] = sq_theta_reg;
    assign h_t2[0]    = t2_reg;
    assign h_b[0]     = Q30_ONE;

    for (genvar k = 0; k < HORNER_STEPS; k++)
    begin : g_horner
        twc_horner_cell #(
            .DIVISOR (horner_div(k))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .tag_in    (h_tag[k]),
            .theta_in  (h_theta[k]),
            .t2_in     (h_t2[k]),
            .b_in      (h_b[k]),
            .tag_out   (h_tag[k+1]),
            .theta_out (h_theta[k+1]),
            .t2_out    (h_t2[k+1]),
            .b_out     (h_b[k+1])
        );
    end

    // Sine, its square, then rounding into Q1.16 in the output register.
    twc_tag_t    s_tag_reg;
    logic [30:0] s_reg;
    twc_tag_t    w_tag_reg;
    logic [31:0] w_reg;
    logic [61:0] s_prod;
    logic [61:0] w_prod;
    logic [32:0] rounded;
    logic [16:0] coef_next;
    logic        out_valid_reg;
    logic [16:0] coefficient_reg;
    logic        index_valid_reg;

    assign s_prod  = 62'(h_theta[HORNER_STEPS]) * 62'(h_b[HORNER_STEPS]);
    assign w_prod  = 62'(s_reg) * 62'(s_reg);
    assign rounded = (33'(w_reg) + 33'(1 << (29 - COEF_FRAC_BITS))) >> (30 - COEF_FRAC_BITS);

    always_comb
    begin
        if (!w_tag_reg.idx_valid)
        begin
            coef_next = '0;
        end
        else if (w_tag_reg.bypass || (rounded > 33'(ALPHA_ONE)))
        begin
            coef_next = ALPHA_ONE;
        end
        else
        begin
            coef_next = rounded[16:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tag_reg     <= '0;
            w_tag_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s_tag_reg     <= h_tag[HORNER_STEPS];
            w_tag_reg     <= s_tag_reg;
            out_valid_reg <= w_tag_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg           <= s_prod[60:30];
            w_reg           <= w_prod[61:30];
            coefficient_reg <= coef_next;
            index_valid_reg <= w_tag_reg.idx_valid;
        end
    end

    assign out_valid   = out_valid_reg;
    assign coefficient = coefficient_reg;
    assign index_valid = index_valid_reg;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !index_valid |-> coefficient == '0)
        else $error("out-of-range index gave a non-zero coefficient");

    a_coef_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> coefficient <= ALPHA_ONE)
        else $error("coefficient above one");

    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow the held output word");
`endif
endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    import twc_pkg::*;

    localparam int LATENCY     = 54;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_LENGTH  = 4096;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [11:0] sample_index;
    logic        out_valid;
    logic        out_stall;
    logic [16:0] coefficient;
    logic        index_valid;

    typedef struct packed {
        logic [16:0] weight;
        logic        in_window;
    } window_word_t;

    // Words waiting to be offered, and the weights expected back in order.
    logic [11:0]  pending_indices[$];
    window_word_t expected_weights[$];

    // The testbench's own copy of the two registers.
    logic [12:0] model_length;
    logic [16:0] model_taper;

    int  error_count;
    int  words_checked;
    int  cycle_count;
    bit  sender_calm;
    bit  receiver_calm;
    bit  hold_receiver;
    bit  in_taken;
    int  sender_gap;
    int  receiver_gap;
    int  hold_cycles;

    tukey_window_coefficient_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_index (sample_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .coefficient  (coefficient),
        .index_valid  (index_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sin^2(pi*x/2) in Q30, with a truncated Taylor series in Horner form.
    function automatic logic [63:0] sine_squared_q30(input logic [63:0] x);
        logic [63:0] theta;
        logic [63:0] theta_sq;
        logic [63:0] bracket;
        logic [63:0] term;
        logic [63:0] sine;
        int          divisors[6];
        begin
            divisors = '{156, 110, 72, 42, 20, 6};
            theta    = (x * 64'(HALF_PI_Q30)) >> 30;
            theta_sq = (theta * theta) >> 30;
            bracket  = 64'(Q30_ONE);
            for (int k = 0; k < 6; k++)
            begin
                term    = ((theta_sq * bracket) >> 30) / 64'(divisors[k]);
                bracket = (term >= 64'(Q30_ONE)) ? 64'd0 : 64'(Q30_ONE) - term;
            end
            sine = (theta * bracket) >> 30;
            return (sine * sine) >> 30;
        end
    endfunction

    // Works out the window weight for one position under the current registers.
    function automatic window_word_t tukey_weight(input logic [11:0] position);
        window_word_t result;
        logic [63:0]  length_eff;
        logic [63:0]  alpha;
        logic [63:0]  last;
        logic [63:0]  distance;
        logic [63:0]  denom;
        logic [63:0]  ramp;
        logic [63:0]  rounded;
        begin
            length_eff = (model_length > 13'(MAX_LENGTH)) ? 64'(MAX_LENGTH) : 64'(model_length);
            alpha      = (model_taper > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(model_taper);
            result     = '0;
            if (64'(position) < length_eff)
            begin
                last             = length_eff - 1;
                distance         = (64'(position) < last - 64'(position)) ?
                                   64'(position) : last - 64'(position);
                denom            = alpha * last;
                result.in_window = 1'b1;
                result.weight    = 17'h1_0000;
                // Inside the taper; a zero taper is rectangular and skips the division.
                if (alpha != 0 && ((distance * 2) << 16) < denom)
                begin
                    ramp    = (distance << 47) / denom;
                    rounded = (sine_squared_q30(ramp) + (64'd1 << 13)) >> 14;
                    result.weight = (rounded > 64'h1_0000) ? 17'h1_0000 : rounded[16:0];
                end
            end
            return result;
        end
    endfunction

    // Register writes happen only while nothing is in flight.
    task automatic write_register(input logic [1:0] index, input logic [16:0] value);
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= index;
            cfg_data  <= value;
            if (index == REG_WINDOW_LENGTH)
                model_length = value[12:0];
            else if (index == REG_TAPER_RATIO)
                model_taper = value;
            @(negedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    // Lets every queued word drain, then the pipeline settle, before the registers move.
    task automatic wait_until_idle();
        begin
            while (pending_indices.size() != 0 || expected_weights.size() != 0)
                @(negedge clk);
            repeat (LATENCY + 4) @(negedge clk);
        end
    endtask

    // Mostly indices inside the window, with both ends favoured and a few anywhere.
    function automatic logic [11:0] random_index();
        int pick;
        int span;
        begin
            pick = $urandom_range(0, 9);
            span = (model_length == 0) ? 1 :
                   ((model_length > 13'd4096) ? 4096 : int'(model_length));
            if (pick == 0)
                return 12'($urandom);
            else if (pick == 1)
                return 12'($urandom_range(0, 3));
            else if (pick == 2)
                return 12'(span - 1 - $urandom_range(0, 3 < span - 1 ? 3 : span - 1));
            else
                return 12'($urandom_range(0, span - 1));
        end
    endfunction

    task automatic run_phase(input logic [16:0] length_value, input logic [16:0] taper_value,
                             input int count);
        begin
            wait_until_idle();
            write_register(REG_WINDOW_LENGTH, length_value);
            write_register(REG_TAPER_RATIO, taper_value);
            for (int i = 0; i < count; i++)
                pending_indices.push_back(random_index());
        end
    endtask

    // Driver: offers queued words, with random bursts of idling unless calmed.
    // A new word goes out only once the previous one was taken at a rising edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (sender_gap > 0)
                begin
                    sender_gap <= sender_gap - 1;
                    in_valid   <= 1'b0;
                end
                else if (pending_indices.size() != 0 && !sender_calm &&
                         $urandom_range(0, 7) == 0)
                begin
                    sender_gap <= $urandom_range(0, 14);
                    in_valid   <= 1'b0;
                end
                else if (pending_indices.size() != 0)
                begin
                    in_valid     <= 1'b1;
                    sample_index <= pending_indices.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random bursts, plus one long hold-off counted here.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_receiver && hold_cycles < 200)
            begin
                hold_cycles <= hold_cycles + 1;
                out_stall   <= 1'b1;
            end
            else if (receiver_gap > 0)
            begin
                receiver_gap <= receiver_gap - 1;
                out_stall    <= 1'b1;
            end
            else if (!receiver_calm && $urandom_range(0, 7) == 0)
            begin
                receiver_gap <= $urandom_range(0, 14);
                out_stall    <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Monitor: predicts on acceptance and checks each result against the oldest expectation.
    always @(posedge clk)
    begin
        window_word_t wanted;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            in_taken    <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                expected_weights.push_back(tukey_weight(sample_index));
            if (out_valid && !out_stall)
            begin
                if (expected_weights.size() == 0)
                begin
                    $error("result word arrived with nothing expected");
                    error_count++;
                end
                else
                begin
                    wanted = expected_weights.pop_front();
                    words_checked++;
                    if (coefficient !== wanted.weight)
                    begin
                        $error("coefficient: expected %0d, got %0d", wanted.weight, coefficient);
                        error_count++;
                    end
                    if (index_valid !== wanted.in_window)
                    begin
                        $error("index_valid: expected %0d, got %0d",
                               wanted.in_window, index_valid);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: ends the run as failed once cycle_count passes CYCLE_LIMIT.
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        sample_index  = '0;
        out_stall     = 1'b0;
        model_length  = 13'd64;
        model_taper   = 17'd32768;
        error_count   = 0;
        words_checked = 0;
        cycle_count   = 0;
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
        hold_receiver = 1'b0;
        in_taken      = 1'b0;
        sender_gap    = 0;
        receiver_gap  = 0;
        hold_cycles   = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed words under the reset registers: both ends, the middle,
        // and positions past the window including the largest index.
        pending_indices = '{12'd0, 12'd1, 12'd15, 12'd16, 12'd31, 12'd32, 12'd62,
                            12'd63, 12'd64, 12'd65, 12'd4095, 12'd2048};
        wait_until_idle();

        // Zero taper, taper above one, zero length, length one, length above
        // maximum, and writes to the two unused register indexes that must be ignored.
        write_register(REG_TAPER_RATIO, 17'd0);
        pending_indices = '{12'd0, 12'd7, 12'd63};
        wait_until_idle();
        write_register(REG_TAPER_RATIO, 17'h1_FFFF);
        write_register(2'd2, 17'h0_0005);
        write_register(2'd3, 17'h1_FFFF);
        pending_indices = '{12'd0, 12'd1, 12'd31, 12'd32, 12'd63};
        wait_until_idle();
        write_register(REG_WINDOW_LENGTH, 17'd0);
        pending_indices = '{12'd0, 12'd4095};
        wait_until_idle();
        write_register(REG_WINDOW_LENGTH, 17'd1);
        pending_indices = '{12'd0, 12'd1};
        wait_until_idle();
        write_register(REG_WINDOW_LENGTH, 17'h1_FFFF);
        pending_indices = '{12'd0, 12'd4095, 12'd2047};

        // Long receiver hold-off while the sender keeps offering words.
        run_phase(17'd4096, 17'd65536, 150);
        hold_cycles   = 0;
        hold_receiver = 1'b1;
        while (hold_cycles < 200)
            @(negedge clk);
        hold_receiver = 1'b0;

        // Random phases across lengths and tapers, extremes included.
        run_phase(17'd2, 17'd65536, 60);
        run_phase(17'd3, 17'd1, 60);
        run_phase(17'd4095, 17'd65535, 150);
        for (int p = 0; p < 8; p++)
            run_phase(17'($urandom_range(1, 300)), 17'($urandom_range(0, 65536)), 120);
        run_phase(17'($urandom_range(301, 8191)), 17'($urandom), 120);

        // Sender pause: nothing offered until every result is home.
        wait_until_idle();

        // Final stretch without idling on either side.
        sender_calm   = 1'b1;
        receiver_calm = 1'b1;
        run_phase(17'd128, 17'd20000, 150);
        wait_until_idle();

        $display("Checked %0d result words over lengths 0 to 8191 and tapers 0 to 1.0 and above.",
                 words_checked);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
